// ===== rtl/lpr_pkg.sv =====
`timescale 1ns / 1ps

package lpr_pkg;

   // Request opcode carried in req_func
   typedef enum logic {
      FUNC_LOAD = 1'b0,   // latch new line endpoints
      FUNC_STEP = 1'b1    // emit next pixel of the active line
   } func_type;

endpackage

// ===== rtl/line_pixel_rasterizer.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Handshake           | Payload
// --------+-----+---------------------+---------------------------------------------
// req     | in  | req_valid/req_ready | req_func, req_x_start, req_y_start,
//         |     |                     | req_x_end, req_y_end
// rsp     | out | rsp_valid/rsp_ready | rsp_pixel_x, rsp_pixel_y, rsp_last
//
// One beat per clock each way while rsp is not stalled. An accepted step beat is
// registered in the input stage, which also registers |dx|, |dy| and the directions;
// then one add on the error term and a +/-1 per axis load its pixel into the result register.
// Reset is synchronous, active high; it drops any active line and empties both stages.
// A stalled rsp holds its beat while the input stage still takes one more req beat;
// loads and steps without an active line drain even then.

module line_pixel_rasterizer #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  logic signed [COORD_BITS-1:0] req_x_start,
   input  logic signed [COORD_BITS-1:0] req_y_start,
   input  logic signed [COORD_BITS-1:0] req_x_end,
   input  logic signed [COORD_BITS-1:0] req_y_end,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_last
);

   localparam int N  = COORD_BITS;
   localparam int EW = COORD_BITS + 3;   // error term and its increments

   // ------------------------------------------------------------------
   // Stage 1: register the beat together with |dx|, |dy| and directions.
   // Both differences are formed in parallel so abs is a plain select.
   // ------------------------------------------------------------------
   logic                s1_valid_ff;
   logic                s1_func_ff;
   logic [N-1:0]        s1_xs_ff, s1_ys_ff;
   logic [N-1:0]        s1_adx_ff, s1_ady_ff;
   logic                s1_xneg_ff, s1_yneg_ff;

   logic [N:0]          xs_ext, ys_ext, xe_ext, ye_ext;
   logic [N:0]          dx_fwd, dx_rev, dy_fwd, dy_rev;
   logic [N-1:0]        s1_adx_in, s1_ady_in;
   logic                s1_xneg_in, s1_yneg_in;

   assign xs_ext = {req_x_start[N-1], req_x_start};
   assign ys_ext = {req_y_start[N-1], req_y_start};
   assign xe_ext = {req_x_end[N-1], req_x_end};
   assign ye_ext = {req_y_end[N-1], req_y_end};

   assign dx_fwd = xe_ext - xs_ext;
   assign dx_rev = xs_ext - xe_ext;
   assign dy_fwd = ye_ext - ys_ext;
   assign dy_rev = ys_ext - ye_ext;

   assign s1_xneg_in = dx_fwd[N];
   assign s1_yneg_in = dy_fwd[N];
   assign s1_adx_in  = s1_xneg_in ? dx_rev[N-1:0] : dx_fwd[N-1:0];
   assign s1_ady_in  = s1_yneg_in ? dy_rev[N-1:0] : dy_fwd[N-1:0];

   // ------------------------------------------------------------------
   // Stage 2: line state and the result register
   // ------------------------------------------------------------------
   logic                active_ff, first_pending_ff;
   logic                x_major_ff, step_x_neg_ff, step_y_neg_ff;
   logic [N-1:0]        cur_x_ff, cur_y_ff;
   logic [N-1:0]        pixels_left_ff;
   logic signed [EW-1:0] error_term_ff;
   logic signed [EW-1:0] inc_diag_ff;      // 2*minor - 2*major
   logic signed [EW-1:0] inc_straight_ff;  // 2*minor

   logic                rsp_valid_ff;
   logic [N-1:0]        rsp_pixel_x_ff, rsp_pixel_y_ff;
   logic                rsp_last_ff;

   logic                out_free, is_step, is_load, produce, s1_go;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_step  = (s1_func_ff == lpr_pkg::FUNC_STEP);
   assign is_load  = (s1_func_ff == lpr_pkg::FUNC_LOAD);
   assign produce  = is_step && active_ff;
   // a beat leaves stage 1 unless it needs the result register and that is full
   assign s1_go    = s1_valid_ff && (!produce || out_free);
   assign req_ready = !s1_valid_ff || s1_go;

   // load: major axis, initial error and the two increments
   logic                 x_major_in;
   logic [N-1:0]         dmaj, dmin;
   logic signed [EW-1:0] maj_e, min2_e;
   logic signed [EW-1:0] err_init, inc_diag_init;

   assign x_major_in    = s1_adx_ff > s1_ady_ff;   // tie goes y-major
   assign dmaj          = x_major_in ? s1_adx_ff : s1_ady_ff;
   assign dmin          = x_major_in ? s1_ady_ff : s1_adx_ff;
   assign maj_e         = signed'({3'b000, dmaj});
   assign min2_e        = signed'({2'b00, dmin, 1'b0});
   assign err_init      = min2_e - maj_e;
   assign inc_diag_init = min2_e - (maj_e <<< 1);

   // step: one add on the error term, +/-1 on each coordinate
   logic                 diag, move_x, move_y, is_last;
   logic signed [EW-1:0] err_step;
   logic [N-1:0]         x_step, y_step, cur_x_in, cur_y_in, pixels_left_in;

   assign diag     = !error_term_ff[EW-1];
   assign err_step = error_term_ff + (diag ? inc_diag_ff : inc_straight_ff);
   assign move_x   = x_major_ff || diag;
   assign move_y   = !x_major_ff || diag;
   assign x_step   = step_x_neg_ff ? {N{1'b1}} : N'(1);
   assign y_step   = step_y_neg_ff ? {N{1'b1}} : N'(1);

   always_comb begin
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      pixels_left_in = pixels_left_ff;
      if (first_pending_ff) begin
         // start pixel goes out untouched
         is_last = (pixels_left_ff == '0);
      end else begin
         if (move_x) begin
            cur_x_in = cur_x_ff + x_step;
         end
         if (move_y) begin
            cur_y_in = cur_y_ff + y_step;
         end
         pixels_left_in = pixels_left_ff - N'(1);
         is_last        = (pixels_left_ff == N'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         s1_func_ff <= req_func;
         s1_xs_ff   <= req_x_start;
         s1_ys_ff   <= req_y_start;
         s1_adx_ff  <= s1_adx_in;
         s1_ady_ff  <= s1_ady_in;
         s1_xneg_ff <= s1_xneg_in;
         s1_yneg_ff <= s1_yneg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff        <= 1'b0;
         first_pending_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (s1_go && is_load) begin
            active_ff        <= 1'b1;
            first_pending_ff <= 1'b1;
         end else if (s1_go && produce) begin
            first_pending_ff <= 1'b0;
            if (is_last) begin
               active_ff <= 1'b0;
            end
         end
         if (s1_go && produce) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (s1_go && is_load) begin
         cur_x_ff        <= s1_xs_ff;
         cur_y_ff        <= s1_ys_ff;
         x_major_ff      <= x_major_in;
         step_x_neg_ff   <= s1_xneg_ff;
         step_y_neg_ff   <= s1_yneg_ff;
         pixels_left_ff  <= dmaj;
         error_term_ff   <= err_init;
         inc_diag_ff     <= inc_diag_init;
         inc_straight_ff <= min2_e;
      end else if (s1_go && produce) begin
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         pixels_left_ff <= pixels_left_in;
         if (!first_pending_ff) begin
            error_term_ff <= err_step;
         end
         rsp_pixel_x_ff <= cur_x_in;
         rsp_pixel_y_ff <= cur_y_in;
         rsp_last_ff    <= is_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pixel_x = signed'(rsp_pixel_x_ff);
   assign rsp_pixel_y = signed'(rsp_pixel_y_ff);
   assign rsp_last    = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_first_needs_active: assert property (@(posedge clock) disable iff (reset)
      first_pending_ff |-> active_ff)
      else $error("first pixel pending without an active line");

   a_steps_remain: assert property (@(posedge clock) disable iff (reset)
      (active_ff && !first_pending_ff) |-> (pixels_left_ff != '0))
      else $error("active line with no major-axis steps left");

   a_load_arms: assert property (@(posedge clock) disable iff (reset)
      (s1_go && is_load) |=> (active_ff && first_pending_ff))
      else $error("load did not arm the line");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (s1_go && produce && is_last) |=> (!active_ff && rsp_valid_ff && rsp_last_ff))
      else $error("last pixel left the line active");

   a_no_pixel_idle: assert property (@(posedge clock) disable iff (reset)
      (s1_go && is_step && !active_ff && (!rsp_valid_ff || rsp_ready)) |=> !rsp_valid_ff)
      else $error("pixel produced without an active line");

endmodule
